// File: rtl/core/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg: shared types and constants for the planar RLE plane decoder
// Sizes, configuration register codes, sequencer states and the pixel
// command that passes from the sequencer to the line store stage.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    // fixed field widths
    localparam int unsigned CNT_W  = 13;   // config registers, row counter
    localparam int unsigned COL_W  = 12;   // column / line store address
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned CIDX_W = 1;

    localparam logic [CIDX_W-1:0] CFG_LINE_WIDTH   = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_PLANE_HEIGHT = 1'd1;

    localparam logic [CNT_W-1:0] CFG_RESET_VAL = 13'd64;
    localparam logic [CNT_W-1:0] WIDTH_MAX     = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] HEIGHT_MAX    = CNT_W'(MAX_HEIGHT);

    // run codes: nibble-swapped control byte inside this range is a long run
    localparam logic [7:0] LONG_RUN_MIN = 8'd16;
    localparam logic [7:0] LONG_RUN_MAX = 8'd47;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BYTE,
        S_RUN
    } t_seq_state;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic [PIX_W-1:0] colour;
        logic             use_mem;   // add to the pixel above
        logic             last;
        logic             done;
        logic             overrun;
    } t_pix_cmd;

endpackage

// File: rtl/core/prd_seq.sv
// ----------------------------------------------------------------------------
// prd_seq: control byte sequencer
// Takes stream bytes, tracks raw/run counts, position and colour, and
// issues at most one pixel command per cycle, held while the line store stage stalls.
// ----------------------------------------------------------------------------
module prd_seq
    import prd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_width,
    input  logic [CNT_W-1:0] i_height,
    input  logic             i_byte_valid,
    output logic             o_byte_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output t_pix_cmd         o_cmd
);

    t_seq_state       r_state, n_state;
    logic [7:0]       r_byte, n_byte;
    logic             r_start, n_start;
    logic [COL_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_colour, n_colour;
    logic [3:0]       r_raw, n_raw;
    logic [5:0]       r_run, n_run;
    logic             r_drop, n_drop;

    // effective state (start_plane applied)
    logic             start_eff;
    logic [COL_W-1:0] e_col;
    logic [CNT_W-1:0] e_row;
    logic [PIX_W-1:0] e_colour;
    logic [3:0]       e_raw;
    logic [5:0]       e_run;
    logic             e_drop;

    logic             plane_over;
    logic             raw_path;
    logic [3:0]       raw_n;
    logic [PIX_W-1:0] delta;
    logic [7:0]       swapped;
    logic             is_long;
    logic [5:0]       c_run;
    logic [3:0]       c_raw;

    logic             emit;
    logic             stall;
    logic [PIX_W-1:0] px_colour;
    logic [3:0]       px_raw;
    logic [5:0]       px_run;
    logic [CNT_W-1:0] col_inc;
    logic [CNT_W-1:0] row_inc;
    logic             row_end;
    logic             overrun;
    logic             px_last;

    // decode
    always_comb begin
        start_eff = (r_state == S_BYTE) && r_start;
        e_col     = start_eff ? '0 : r_col;
        e_row     = start_eff ? '0 : r_row;
        e_colour  = start_eff ? '0 : r_colour;
        e_raw     = start_eff ? '0 : r_raw;
        e_run     = start_eff ? '0 : r_run;
        e_drop    = start_eff ? 1'b0 : r_drop;

        plane_over = (e_row >= i_height);
        raw_path   = (e_raw != 4'd0);
        raw_n      = e_raw - 4'd1;

        // first row: literal colour; later rows: zigzag delta (bit 0 is the sign)
        if (e_row == '0) begin
            delta = r_byte;
        end else if (r_byte[0]) begin
            delta = ~{1'b0, r_byte[7:1]};
        end else begin
            delta = {1'b0, r_byte[7:1]};
        end

        swapped = {r_byte[3:0], r_byte[7:4]};
        is_long = (swapped >= LONG_RUN_MIN) && (swapped <= LONG_RUN_MAX);
        c_run   = is_long ? swapped[5:0] : {2'b00, r_byte[3:0]};
        c_raw   = is_long ? 4'd0 : r_byte[7:4];

        emit = ((r_state == S_BYTE) && !plane_over && raw_path && !e_drop)
             || (r_state == S_RUN);
        stall = emit && !i_cmd_ready;

        px_colour = (r_state == S_RUN) ? r_colour : delta;
        px_raw    = (r_state == S_RUN) ? r_raw : raw_n;
        px_run    = (r_state == S_RUN) ? (r_run - 6'd1) : e_run;

        col_inc = {1'b0, e_col} + CNT_W'(1);
        row_inc = e_row + CNT_W'(1);
        row_end = (col_inc >= i_width);
        overrun = row_end && ((px_raw != 4'd0) || (px_run != 6'd0));
        if (r_state == S_RUN) begin
            px_last = row_end || (px_run == 6'd0);
        end else begin
            px_last = row_end || (raw_n != 4'd0) || (e_run == 6'd0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_byte_valid) n_state = S_BYTE;
            end
            S_BYTE: begin
                if (plane_over) begin
                    n_state = S_IDLE;
                end else if (raw_path) begin
                    if (e_drop) begin
                        n_state = S_IDLE;
                    end else if (!stall) begin
                        if (!row_end && (raw_n == 4'd0) && (e_run != 6'd0)) begin
                            n_state = S_RUN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if ((c_raw == 4'd0) && (c_run != 6'd0)) begin
                    n_state = S_RUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                if (!stall && (row_end || (px_run == 6'd0))) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_byte   = r_byte;
        n_start  = r_start;
        n_col    = r_col;
        n_row    = r_row;
        n_colour = r_colour;
        n_raw    = r_raw;
        n_run    = r_run;
        n_drop   = r_drop;

        o_byte_ready = (r_state == S_IDLE);
        o_cmd_valid  = emit;
        o_cmd.col     = e_col;
        o_cmd.row     = e_row[COL_W-1:0];
        o_cmd.colour  = px_colour;
        o_cmd.use_mem = (e_row != '0);
        o_cmd.last    = px_last;
        o_cmd.done    = row_end && (row_inc >= i_height);
        o_cmd.overrun = overrun;

        unique case (r_state)
            S_IDLE: begin
                if (i_byte_valid) begin
                    n_byte  = i_byte;
                    n_start = i_start;
                end
            end
            S_BYTE: begin
                if (!stall) begin
                    n_col    = e_col;
                    n_row    = e_row;
                    n_colour = e_colour;
                    n_raw    = e_raw;
                    n_run    = e_run;
                    n_drop   = e_drop;
                    if (plane_over) begin
                        n_raw  = '0;
                        n_run  = '0;
                        n_drop = 1'b0;
                    end else if (raw_path) begin
                        n_raw = raw_n;
                        if (e_drop) begin
                            if (raw_n == 4'd0) n_drop = 1'b0;
                        end else begin
                            n_colour = delta;
                        end
                    end else begin
                        n_run = c_run;
                        n_raw = c_raw;
                    end
                end
            end
            S_RUN: begin
                if (!stall) n_run = px_run;
            end
            default: ;
        endcase

        // position update for an issued pixel
        if (emit && !stall) begin
            if (row_end) begin
                n_col    = '0;
                n_row    = row_inc;
                n_colour = '0;
                if (overrun) begin
                    n_run  = '0;
                    n_drop = (px_raw != 4'd0);
                end
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_colour <= '0;
            r_raw    <= '0;
            r_run    <= '0;
            r_drop   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_start  <= n_start;
            r_col    <= n_col;
            r_row    <= n_row;
            r_colour <= n_colour;
            r_raw    <= n_raw;
            r_run    <= n_run;
            r_drop   <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    a_drop_has_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_raw != 4'd0))
        else $error("drop flag set with no raw bytes pending");

    a_run_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((r_run != 6'd0) && (r_raw == 4'd0)))
        else $error("run state without a pending run");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && i_cmd_ready && o_cmd.last) |=> (r_state != S_RUN))
        else $error("sequencer kept running after last pixel of a byte");

endmodule

// File: rtl/core/prd_pix.sv
// ----------------------------------------------------------------------------
// prd_pix: line store stage
// Reads the pixel above and, after row 0, adds the delta; writes back and
// holds the result in the output register. Same-entry read/write collisions are forwarded.
// ----------------------------------------------------------------------------
module prd_pix
    import prd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_pix_cmd    i_cmd,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser
);

    logic [PIX_W-1:0] r_line [MAX_WIDTH];
    logic [PIX_W-1:0] r_rdata;

    logic             r_b_valid;
    logic             r_b_fresh;   // first cycle in stage: read data valid
    t_pix_cmd         r_b;
    logic [PIX_W-1:0] r_b_val;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_val;

    logic             r_o_valid;
    logic [31:0]      r_o_data;
    logic             r_o_last;
    logic [1:0]       r_o_user;

    logic             o_free;
    logic             b_go;
    logic             issue;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] b_value;
    logic             wr_en;

    always_comb begin
        o_free      = !r_o_valid || i_m_axis_tready;
        b_go        = r_b_valid && o_free;
        o_cmd_ready = !r_b_valid || b_go;
        issue       = i_cmd_valid && o_cmd_ready;
        above       = r_fwd ? r_fwd_val : r_rdata;
        if (!r_b_fresh) begin
            b_value = r_b_val;
        end else if (r_b.use_mem) begin
            b_value = above + r_b.colour;
        end else begin
            b_value = r_b.colour;
        end
        wr_en = r_b_valid && r_b_fresh;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (wr_en) r_line[r_b.col] <= b_value;
        if (issue) r_rdata <= r_line[i_cmd.col];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_fresh <= 1'b0;
            r_fwd     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_b_fresh <= issue;
            r_fwd     <= issue && wr_en && (i_cmd.col == r_b.col);
            if (issue) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (o_free) r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_val <= b_value;
        r_b_val   <= b_value;
        if (issue) r_b <= i_cmd;
        if (o_free) begin
            r_o_data <= {r_b.row, r_b.col, b_value};
            r_o_last <= r_b.last;
            r_o_user <= {r_b.overrun, r_b.done};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_user;

    a_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !o_cmd_ready) |=> i_cmd_valid)
        else $error("pixel command withdrawn while stage is blocked");

    a_fwd_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b_fresh)
        else $error("forward flag without fresh read data");

    a_fresh_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_fresh |-> r_b_valid)
        else $error("fresh read data in an empty stage");

endmodule

// File: rtl/core/planar_rle_plane_decoder.sv
// ----------------------------------------------------------------------------
// planar_rle_plane_decoder: RLE colour plane decoder, one stream byte a transfer
// Decodes a byte-wide planar RLE plane into pixels with their coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one compressed byte per transfer in tdata[7:0]; tuser set
//   marks the start of a plane (position back to row 0, column 0 first).
//   Master stream: one transfer per decoded pixel; tlast marks the last pixel
//   caused by an input byte, tuser[0] the final pixel of the plane and
//   tuser[1] a row end that cut a run or pending raw bytes short.
//   Config port: write line_width (index 0) or plane_height (index 1) while
//   the block is idle; both reset to 64.
// Path: a raw byte's pixel passes the byte register, the line store stage
//   and the output register; a bare run issues from S_RUN after S_BYTE.
// Throughput: a byte passes capture and decode and issues at most one
//   pixel itself; a run then issues one pixel a cycle while the master
//   side accepts transfers.
// Reset: synchronous; position, counts and colour clear; the line store is
//   not cleared (row 0 only writes it, later rows read what row above left).
// Stall: a held master transfer stops the sequencer; the slave side stays
//   closed until the current byte's pixels have all issued.
// ----------------------------------------------------------------------------
module planar_rle_plane_decoder
    import prd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] stream_byte
    input  logic              i_s_axis_tuser,   // [0] start_plane
    // master stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // [7:0] value, [19:8] column, [31:20] row
    output logic              o_m_axis_tlast,   // last_of_item
    output logic [1:0]        o_m_axis_tuser,   // [0] plane_done, [1] row_overrun
    // config
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    logic [CNT_W-1:0] r_width;
    logic [CNT_W-1:0] r_height;
    logic [CNT_W-1:0] width_eff;
    logic [CNT_W-1:0] height_eff;

    logic             cmd_valid;
    logic             cmd_ready;
    t_pix_cmd         cmd;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RESET_VAL;
            r_height <= CFG_RESET_VAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_width  <= i_cfg_data;
                CFG_PLANE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // width 0 acts as 1; both saturate at 4096 (line store size, 12-bit row field)
    always_comb begin
        if (r_width == '0) begin
            width_eff = CNT_W'(1);
        end else if (r_width > WIDTH_MAX) begin
            width_eff = WIDTH_MAX;
        end else begin
            width_eff = r_width;
        end
        height_eff = (r_height > HEIGHT_MAX) ? HEIGHT_MAX : r_height;
    end

    prd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (width_eff),
        .i_height     (height_eff),
        .i_byte_valid (i_s_axis_tvalid),
        .o_byte_ready (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_start      (i_s_axis_tuser),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    prd_pix u_pix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd           (cmd),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
